// ===== sv/voxrt_pkg.sv =====
// ============================================================================
// voxrt_pkg
// Types and codes shared by the voxel ray traversal modules.
// ============================================================================
`default_nettype none
package voxrt_pkg;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_HIT    = 2'd1;
    localparam logic [1:0] KIND_LENGTH = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd3;

    localparam logic [31:0] DIST_FAR  = 32'hFFFF_FFFF;
    localparam logic [31:0] HALF_Q16  = 32'h0000_8000;
    localparam logic [31:0] ONE_Q1_31 = 32'h8000_0000;
    localparam logic [2:0]  DIV_LAST  = 3'd5;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic        [30:0] ray_length;
        logic               occupied;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
        logic        [1:0]  kind;
    } t_out_item;

    typedef struct packed {
        logic       take;
        logic       setup;
        logic       div_go;
        logic       div_wr;
        logic [2:0] div_idx;
        logic       resp;
    } t_ctrl;

    typedef struct packed {
        logic in_op;
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== sv/voxrt_div.sv =====
// ============================================================================
// voxrt_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ============================================================================
`default_nettype none
module voxrt_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [31:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quo
);
    logic        r_run;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [15:0] r_rem;
    logic [15:0] r_d;
    logic [16:0] rem_sh;
    logic        ge;

    always_comb begin
        rem_sh = {r_rem, r_q[31]};
        ge     = rem_sh >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_d   <= i_den;
        end else if (r_run) begin
            r_q   <= {r_q[30:0], ge};
            r_rem <= ge ? 16'(rem_sh - {1'b0, r_d}) : rem_sh[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

// ===== sv/voxrt_dp.sv =====
// ============================================================================
// voxrt_dp
// Ray state, setup arithmetic, axis step logic and the output register.
// ============================================================================
`default_nettype none
module voxrt_dp #(
    parameter logic [30:0] VOFF_RESET = 31'd8388608
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire voxrt_pkg::t_ctrl      i_ctrl,
    output voxrt_pkg::t_status         o_status,
    input  wire voxrt_pkg::t_in_item   i_in_data,
    input  wire logic                  i_cfg_wr,
    input  wire logic [30:0]           i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output voxrt_pkg::t_out_item       o_out_data
);
    import voxrt_pkg::*;

    t_in_item   r_item;
    logic [30:0] r_voff;
    logic        r_busy;
    logic [15:0] r_cell [3];
    logic [1:0]  r_sign [3];
    logic [31:0] r_sd   [3];
    logic [31:0] r_nb   [3];
    logic [31:0] r_limit;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] p      [3];
    logic [15:0] dir    [3];
    logic [15:0] mag    [3];
    logic [31:0] bnum   [3];
    logic [16:0] rr     [3];
    logic [31:0] org    [3];
    logic [32:0] key    [3];
    logic [1:0]  sel;
    logic        at_end;
    logic [32:0] sum;
    logic [1:0]  ax;
    logic [31:0] div_num;
    logic [15:0] div_den;
    logic        div_done;
    logic [31:0] div_quo;
    logic        out_free;

    always_comb begin
        org[0] = r_item.origin_x;
        org[1] = r_item.origin_y + {1'b0, r_voff};
        org[2] = r_item.origin_z;
        dir[0] = r_item.dir_x;
        dir[1] = r_item.dir_y;
        dir[2] = r_item.dir_z;
        for (int a = 0; a < 3; a++) begin
            p[a]   = org[a] + HALF_Q16;
            mag[a] = dir[a][15] ? 16'(-dir[a]) : dir[a];
            rr[a]  = dir[a][15] ? {1'b0, p[a][15:0]} : 17'h10000 - {1'b0, p[a][15:0]};
            bnum[a] = {rr[a], 15'd0};
            key[a] = (r_sign[a] == SIGN_NONE) ? 33'h1_0000_0000 : {1'b0, r_nb[a]};
        end
        // Ties go to y over x, and to z over the chosen one of x and y.
        if (key[0] < key[1]) sel = (key[0] < key[2]) ? 2'd0 : 2'd2;
        else                 sel = (key[1] < key[2]) ? 2'd1 : 2'd2;
        at_end = key[sel] >= {1'b0, r_limit};
        sum    = {1'b0, r_nb[sel]} + {1'b0, r_sd[sel]};
        ax      = i_ctrl.div_idx[2:1];
        div_num = i_ctrl.div_idx[0] ? bnum[ax] : ONE_Q1_31;
        div_den = (mag[ax] == 16'd0) ? 16'd1 : mag[ax];
    end

    voxrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_ctrl.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voff      <= VOFF_RESET;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= '0;
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= '0;
                r_sign[a] <= SIGN_NONE;
                r_sd[a]   <= '0;
                r_nb[a]   <= '0;
            end
        end else begin
            if (i_cfg_wr) r_voff <= i_cfg_data;
            if (r_out_valid && !i_out_stall && !i_ctrl.resp) r_out_valid <= 1'b0;
            if (i_ctrl.setup) begin
                r_busy  <= 1'b1;
                r_limit <= {1'b0, r_item.ray_length};
                for (int a = 0; a < 3; a++) begin
                    r_cell[a] <= p[a][31:16];
                    if (dir[a] == 16'd0) begin
                        r_sign[a] <= SIGN_NONE;
                        r_sd[a]   <= DIST_FAR;
                        r_nb[a]   <= DIST_FAR;
                    end else begin
                        r_sign[a] <= dir[a][15] ? SIGN_MINUS : SIGN_PLUS;
                    end
                end
            end
            if (i_ctrl.div_wr && r_sign[ax] != SIGN_NONE) begin
                if (i_ctrl.div_idx[0]) r_nb[ax] <= div_quo;
                else                   r_sd[ax] <= div_quo;
            end
            if (i_ctrl.resp) begin
                r_out_valid <= 1'b1;
                if (r_item.operation == OP_ANSWER && !r_busy) begin
                    r_out <= '{cell_x: '0, cell_y: '0, cell_z: '0, kind: KIND_IDLE};
                end else if (r_item.operation == OP_ANSWER && r_item.occupied) begin
                    r_busy <= 1'b0;
                    r_out  <= '{cell_x: r_cell[0], cell_y: r_cell[1], cell_z: r_cell[2],
                               kind: KIND_HIT};
                end else if (at_end) begin
                    r_busy <= 1'b0;
                    r_out  <= '{cell_x: r_cell[0], cell_y: r_cell[1], cell_z: r_cell[2],
                               kind: KIND_LENGTH};
                end else begin
                    for (int a = 0; a < 3; a++) begin
                        if (sel == 2'(a)) begin
                            r_cell[a] <= (r_sign[a] == SIGN_PLUS) ? r_cell[a] + 16'd1
                                                                  : r_cell[a] - 16'd1;
                        end
                    end
                    r_nb[sel] <= sum[32] ? DIST_FAR : sum[31:0];
                    r_out <= '{cell_x: (sel == 2'd0) ? ((r_sign[0] == SIGN_PLUS) ?
                                   r_cell[0] + 16'd1 : r_cell[0] - 16'd1) : r_cell[0],
                               cell_y: (sel == 2'd1) ? ((r_sign[1] == SIGN_PLUS) ?
                                   r_cell[1] + 16'd1 : r_cell[1] - 16'd1) : r_cell[1],
                               cell_z: (sel == 2'd2) ? ((r_sign[2] == SIGN_PLUS) ?
                                   r_cell[2] + 16'd1 : r_cell[2] - 16'd1) : r_cell[2],
                               kind: KIND_QUERY};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) r_item <= i_in_data;
    end

    assign o_status    = '{in_op: i_in_data.operation, div_done: div_done, out_free: out_free};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ===== sv/voxrt_ctrl.sv =====
// ============================================================================
// voxrt_ctrl
// Sequencer: takes a request, runs the ray setup divisions, issues the step.
// ============================================================================
`default_nettype none
module voxrt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire voxrt_pkg::t_status i_status,
    output voxrt_pkg::t_ctrl        o_ctrl
);
    import voxrt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_DIV_GO, S_DIV_WAIT, S_RESP} t_state;

    t_state     r_state;
    logic [2:0] r_idx;
    logic       take;

    assign take = (r_state == S_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) r_state <= (i_status.in_op == OP_START) ? S_SETUP : S_RESP;
                end
                S_SETUP: begin
                    r_idx   <= '0;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_status.div_done) begin
                        if (r_idx == DIV_LAST) begin
                            r_state <= S_RESP;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_RESP: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_ctrl = '{take:    take,
                      setup:   r_state == S_SETUP,
                      div_go:  r_state == S_DIV_GO,
                      div_wr:  (r_state == S_DIV_WAIT) && i_status.div_done,
                      div_idx: r_idx,
                      resp:    (r_state == S_RESP) && i_status.out_free};
endmodule
`default_nettype wire

// ===== sv/voxel_ray_traversal_top.sv =====
// ============================================================================
// voxel_ray_traversal_top
// Fixed-point 3D voxel grid walker with a query/answer handshake.
// ============================================================================
// Input channel (i_in_valid/o_in_stall/i_in_data) carries either a start
// request, which loads a new ray, or an answer to the last voxel query.
// Each request gives exactly one result on o_out_valid/i_out_stall/o_out_data:
// a voxel query, an end on hit, an end at length, or a stray-answer code.
// An answer goes from acceptance straight to the response state. A start first
// passes the setup state, then six runs of the shared divider (launch, 32
// quotient bits, done), for step distance and first boundary of each axis,
// before the response state, which writes the result into the output
// register once that register is free; the block then returns to idle.
// One request is in work at a time; o_in_stall is high while it runs.
// When the receiver stalls, the result holds in the output register; the next
// request may still be taken, but its result waits until that register is free.
// The configuration channel writes vertical_offset; it is always ready.
// Synchronous reset clears the ray, leaves no result pending and restores
// vertical_offset to half the column height in Q16.16.
// ============================================================================
`default_nettype none
module voxel_ray_traversal_top #(
    parameter int COLUMN_HEIGHT = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire voxrt_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output voxrt_pkg::t_out_item       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [30:0]           i_cfg_data
);
    import voxrt_pkg::*;

    localparam logic [63:0] VOFF_FULL = 64'(COLUMN_HEIGHT / 2) << 16;

    t_ctrl   ctrl;
    t_status status;

    assign o_cfg_ready = 1'b1;

    voxrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    voxrt_dp #(
        .VOFF_RESET (VOFF_FULL[30:0])
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

// ===== sv/voxrt_checker.sv =====
// ============================================================================
// voxrt_checker
// Port-level checks on the voxel ray traversal block.
// ============================================================================
`default_nettype none
module voxrt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire voxrt_pkg::t_out_item o_out_data
);
    import voxrt_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A request is worked alone: after acceptance the input side stalls.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken during work");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_IDLE |->
        o_out_data.cell_x == 16'sd0 && o_out_data.cell_y == 16'sd0 &&
        o_out_data.cell_z == 16'sd0)
        else $error("stray answer result carries a cell");
endmodule

bind voxel_ray_traversal_top voxrt_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for voxel_ray_traversal_top. A scoreboard class carries
// its own copy of the ray walk and predicts one result per accepted request;
// the results are compared field by field in order. Directed rays come first,
// then random rays, with well-formed answer sequences and some noise.
// ============================================================================
module tb_top;
    import voxrt_pkg::*;

    localparam int COLUMN_HEIGHT_Q16 = 256 / 2 * 65536;

    class walk_scoreboard;
        logic [30:0] v_offset;
        bit          walking;
        logic [15:0] pos [3];
        logic [1:0]  sgn [3];
        logic [31:0] stride [3];
        logic [31:0] bound [3];
        logic [31:0] limit;
        t_out_item   pending [$];
        int          errors;

        function void clear();
            v_offset = 31'(COLUMN_HEIGHT_Q16);
            walking = 0;
            limit = '0;
            for (int a = 0; a < 3; a++) begin
                pos[a] = '0; sgn[a] = SIGN_NONE; stride[a] = '0; bound[a] = '0;
            end
        endfunction

        function logic [32:0] key(int a);
            return sgn[a] == SIGN_NONE ? 33'h1_0000_0000 : {1'b0, bound[a]};
        endfunction

        function void push(logic [1:0] k);
            t_out_item o;
            o.cell_x = pos[0]; o.cell_y = pos[1]; o.cell_z = pos[2]; o.kind = k;
            pending.push_back(o);
        endfunction

        function void step_walk();
            int a;
            logic [32:0] s;
            if (key(0) < key(1)) a = key(0) < key(2) ? 0 : 2;
            else a = key(1) < key(2) ? 1 : 2;
            if (key(a) >= {1'b0, limit}) begin
                walking = 0;
                push(KIND_LENGTH);
                return;
            end
            pos[a] = sgn[a] == SIGN_PLUS ? pos[a] + 16'd1 : pos[a] - 16'd1;
            s = {1'b0, bound[a]} + {1'b0, stride[a]};
            bound[a] = s[32] ? DIST_FAR : s[31:0];
            push(KIND_QUERY);
        endfunction

        function void load(int a, logic signed [31:0] org, logic [30:0] extra,
                           logic signed [15:0] dir);
            logic [63:0] p, m, r;
            p = 64'(signed'(org)) + 64'(extra) + 64'(HALF_Q16);
            pos[a] = p[31:16];
            if (dir == 0) begin
                sgn[a] = SIGN_NONE; stride[a] = DIST_FAR; bound[a] = DIST_FAR;
                return;
            end
            m = dir < 0 ? 64'(-32'(dir)) : 64'(dir);
            sgn[a] = dir > 0 ? SIGN_PLUS : SIGN_MINUS;
            stride[a] = 32'(64'(ONE_Q1_31) / m);
            r = dir > 0 ? 64'h10000 - {48'd0, p[15:0]} : {48'd0, p[15:0]};
            bound[a] = 32'((r << 15) / m);
        endfunction

        function void note_request(t_in_item it);
            if (it.operation == OP_START) begin
                load(0, it.origin_x, 31'd0, it.dir_x);
                load(1, it.origin_y, v_offset, it.dir_y);
                load(2, it.origin_z, 31'd0, it.dir_z);
                limit = {1'b0, it.ray_length};
                walking = 1;
                step_walk();
            end else if (!walking) begin
                pending.push_back('{cell_x: '0, cell_y: '0, cell_z: '0, kind: KIND_IDLE});
            end else if (it.occupied) begin
                walking = 0;
                push(KIND_HIT);
            end else step_walk();
        endfunction

        function void check_result(t_out_item got);
            t_out_item w;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.cell_x !== w.cell_x) begin
                $error("cell_x expected %0d got %0d", w.cell_x, got.cell_x); errors++;
            end
            if (got.cell_y !== w.cell_y) begin
                $error("cell_y expected %0d got %0d", w.cell_y, got.cell_y); errors++;
            end
            if (got.cell_z !== w.cell_z) begin
                $error("cell_z expected %0d got %0d", w.cell_z, got.cell_z); errors++;
            end
            if (got.kind !== w.kind) begin
                $error("kind expected %0d got %0d", w.kind, got.kind); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data = '0;

    walk_scoreboard sb = new();
    bit             hold_long = 0;

    voxel_ray_traversal_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    function automatic int gap_len();
        return $urandom_range(0, 19) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                @(posedge i_clk) i_out_stall <= 1;
                repeat (400) @(posedge i_clk);
                hold_long = 0;
                i_out_stall <= 0;
            end else begin
                n = $urandom_range(0, 3) == 0 ? gap_len() : 0;
                @(posedge i_clk) i_out_stall <= n != 0;
                repeat (n > 0 ? n - 1 : 0) @(posedge i_clk);
            end
        end
    end

    // The request stays offered after acceptance only until the next call
    // of send or drain, which follows in the same time step.
    task automatic send(t_in_item it);
        int g;
        g = gap_len();
        if ($urandom_range(0, 3) != 0) g = 0;
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_in_data <= it;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(it);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [30:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.v_offset = v;
        i_cfg_valid <= 0;
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item ray(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                                     logic [30:0] len);
        t_in_item it;
        it = '0;
        it.operation = OP_START;
        it.origin_x = $urandom; it.origin_y = $urandom; it.origin_z = $urandom;
        it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
        it.ray_length = len;
        it.occupied = $urandom_range(0, 1) == 1;
        return it;
    endfunction

    function automatic t_in_item answer(bit occ);
        t_in_item it;
        it = '0;
        it.origin_x = $urandom; it.origin_y = $urandom; it.origin_z = $urandom;
        it.dir_x = 16'($urandom); it.dir_y = 16'($urandom); it.dir_z = 16'($urandom);
        it.ray_length = 31'($urandom);
        it.operation = OP_ANSWER;
        it.occupied = occ;
        return it;
    endfunction

    task automatic walk_ray(t_in_item r, int max_answers);
        send(r);
        for (int k = 0; k < max_answers; k++) begin
            if (!sb.walking) break;
            send(answer($urandom_range(0, 15) == 0));
        end
    endtask

    initial begin
        t_in_item it;
        int items;
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: stray answer, zero length, all-zero direction, extremes.
        send(answer(0));
        send(answer(1));
        walk_ray(ray(16'h7FFF, 16'h0000, 16'h0000, 31'd0), 3);
        walk_ray(ray(16'h0000, 16'h0000, 16'h0000, 31'h7FFF_FFFF), 3);
        it = ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h0004_0000);
        it.origin_x = 32'sh7FFF_FFFF; it.origin_y = 32'sh8000_0000; it.origin_z = 0;
        walk_ray(it, 20);
        it = ray(16'h8000, 16'h8000, 16'h8000, 31'h7FFF_FFFF);
        it.origin_x = 32'sh8000_0000; it.origin_y = 32'sh7FFF_FFFF; it.origin_z = -1;
        walk_ray(it, 6);
        walk_ray(ray(16'h0001, 16'hFFFF, 16'h0000, 31'h7FFF_FFFF), 3);
        walk_ray(ray(16'h4000, 16'h4000, 16'h4000, 31'h0010_0000), 4);
        send(ray(16'h5A82, 16'h0000, 16'hA57E, 31'h0010_0000));
        send(ray(16'h2000, 16'h3000, 16'h7000, 31'h0010_0000));
        send(answer(1));
        send(answer(0));

        write_offset(31'h7FFF_FFFF);
        walk_ray(ray(16'h0000, 16'h7FFF, 16'h0000, 31'h0008_0000), 10);
        write_offset(31'h0);
        walk_ray(ray(16'h0000, 16'h8000, 16'h0000, 31'h0008_0000), 10);

        // Long hold-off on the result side while starts keep coming.
        hold_long = 1;
        for (int k = 0; k < 6; k++)
            send(ray(rand_dir(), rand_dir(), rand_dir(), 31'($urandom)));
        drain();

        items = 0;
        for (int phase = 0; phase < 4; phase++) begin
            write_offset(phase == 3 ? 31'(COLUMN_HEIGHT_Q16) : 31'($urandom));
            while (items < (phase + 1) * 430) begin
                if ($urandom_range(0, 9) == 0) begin
                    send($urandom_range(0, 1) ? answer($urandom_range(0, 1) == 1)
                         : ray(rand_dir(), rand_dir(), rand_dir(), 31'($urandom)));
                    items++;
                end else begin
                    it = ray(rand_dir(), rand_dir(), rand_dir(),
                             $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                       : 31'($urandom_range(0, 32'h0020_0000)));
                    send(it);
                    items++;
                    for (int k = 0; k < 30 && sb.walking; k++) begin
                        send(answer($urandom_range(0, 19) == 0));
                        items++;
                    end
                end
            end
        end

        drain();
        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("PASS voxel_ray_traversal_top");
        else
            $display("FAIL voxel_ray_traversal_top");
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL voxel_ray_traversal_top");
        $finish;
    end
endmodule
